@@ sv/mpi_pkg.sv @@
package mpi_pkg;
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_MOD  = 2'd1;
   localparam logic [1:0] STATUS_ZERO_ZERO = 2'd2;
   localparam logic [1:0] STATUS_NO_INV    = 2'd3;
endpackage

@@ sv/mpi_if.sv @@
interface mpi_req_if #(parameter int DATA_WIDTH = 32);
   logic valid;
   logic ready;
   logic [DATA_WIDTH-1:0] base;
   logic [DATA_WIDTH-1:0] exponent;
   logic [DATA_WIDTH-2:0] modulus;
   modport source (output valid, base, exponent, modulus, input ready);
   modport sink (input valid, base, exponent, modulus, output ready);
endinterface

interface mpi_rsp_if #(parameter int DATA_WIDTH = 32);
   logic valid;
   logic ready;
   logic [DATA_WIDTH-1:0] result;
   logic [1:0] status;
   modport source (output valid, result, status, input ready);
   modport sink (input valid, result, status, output ready);
endinterface

@@ sv/mpi_mulmod.sv @@
// Bit-serial modular multiply: one multiplier bit per cycle, MSB first.
module mpi_mulmod #(
   parameter int W = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] r
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  r_ff, r_in, b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    dbl, dsub, add, asub;
   logic [W-1:0]  t;

   always_comb begin
      dbl  = {r_ff, 1'b0};
      dsub = dbl - {1'b0, m};
      t    = (dbl >= {1'b0, m}) ? dsub[W-1:0] : dbl[W-1:0];
      add  = {1'b0, t} + {1'b0, a};
      asub = add - {1'b0, m};
      r_in = r_ff; b_in = b_ff; cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         r_in = '0; b_in = b; cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in = b_ff[W-1] ? ((add >= {1'b0, m}) ? asub[W-1:0] : add[W-1:0]) : t;
         b_in = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; b_ff <= b_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign r = r_ff;
endmodule

@@ sv/mpi_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module mpi_divider #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  q_ff, q_in, r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    sh;

   always_comb begin
      sh = {r_ff, q_ff[W-1]};
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = num; r_in = '0; cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, den}) begin
            r_in = W'(sh - {1'b0, den}); q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = sh[W-1:0]; q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quo = q_ff;
   assign rem = r_ff;
endmodule

@@ sv/modular_power_with_inverse.sv @@
// Modular power: result = base**exponent mod modulus (truncated remainders; negative
// exponents return the inverse). One request at a time. The base is first reduced
// through the bit-serial divider; each of the significant exponent bits then takes a
// multiply and a square when set or a square only when clear, for W = DATA_WIDTH-1
// multiplier bits at one bit per cycle. A negative exponent adds up to about 1.44*W
// Euclid steps through the divider. Special cases present their result the cycle after
// the request beat. The result register holds one beat.
module modular_power_with_inverse
   import mpi_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   mpi_req_if.sink req,
   mpi_rsp_if.source rsp
);
   localparam int DW = DATA_WIDTH;
   localparam int MW = DATA_WIDTH - 1;
   localparam int CW = DATA_WIDTH + 1;

   localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_REDW = 4'd2, S_BIT = 4'd3,
      S_MULW = 4'd4, S_SQW = 4'd5, S_EUC = 4'd6, S_EUCW = 4'd7, S_EUCU = 4'd8,
      S_FIN = 4'd9, S_OUT = 4'd10;

   logic [3:0]    st_ff, st_in;
   logic [MW-1:0] m_ff, m_in, sq_ff, sq_in, acc_ff, acc_in;
   logic [DW-1:0] e_ff, e_in;
   logic          eneg_ff, eneg_in, pneg_ff, pneg_in;
   logic [MW-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic signed [CW-1:0] c0_ff, c0_in, c1_ff, c1_in;
   logic [DW-1:0] res_ff, res_in;
   logic [1:0]    stat_ff, stat_in;
   logic [DW-1:0] bmag_ff, bmag_in;

   logic          mm_start, mm_done;
   logic [MW-1:0] mm_a, mm_b, mm_r;
   logic          dv_start, dv_done;
   logic [DW-1:0] dv_num, dv_den, dv_q, dv_r;

   logic [DW-1:0] bmag, emag;
   logic          bneg, eneg;
   logic signed [CW-1:0] qc, ct;
   logic [CW-1:0] xmag;
   logic          xneg, rn;

   mpi_mulmod #(.W(MW)) u_mul (
      .clock(clock), .reset(reset), .start(mm_start), .a(mm_a), .b(mm_b), .m(m_ff),
      .done(mm_done), .r(mm_r));
   mpi_divider #(.W(DW)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quo(dv_q), .rem(dv_r));

   assign bneg = req.base[DW-1];
   assign eneg = req.exponent[DW-1];
   assign bmag = bneg ? DW'(-req.base) : req.base;
   assign emag = eneg ? DW'(-req.exponent) : req.exponent;
   assign req.ready = (st_ff == S_IDLE) && !rsp.valid;
   assign rsp.valid = (st_ff == S_OUT);
   assign rsp.result = res_ff;
   assign rsp.status = stat_ff;

   always_comb begin
      st_in = st_ff; m_in = m_ff; sq_in = sq_ff; acc_in = acc_ff; e_in = e_ff;
      eneg_in = eneg_ff; pneg_in = pneg_ff; r0_in = r0_ff; r1_in = r1_ff;
      c0_in = c0_ff; c1_in = c1_ff; res_in = res_ff; stat_in = stat_ff;
      bmag_in = bmag_ff;
      mm_start = 1'b0; mm_a = acc_ff; mm_b = sq_ff;
      dv_start = 1'b0; dv_num = bmag_ff; dv_den = DW'(m_ff);
      qc = '0; ct = '0; xmag = '0; xneg = 1'b0; rn = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               m_in = req.modulus; e_in = emag; eneg_in = eneg; bmag_in = bmag;
               pneg_in = bneg && emag[0];
               stat_in = STATUS_OK; st_in = S_OUT;
               if (req.modulus == '0) begin
                  res_in = '0; stat_in = STATUS_ZERO_MOD;
               end else if (req.base == '0 && req.exponent == '0) begin
                  res_in = DW'(req.modulus); stat_in = STATUS_ZERO_ZERO;
               end else if (req.exponent == '0) begin
                  res_in = (req.modulus == MW'(1)) ? '0 : DW'(1);
               end else if (req.base == '0) begin
                  if (eneg) begin
                     res_in = DW'(req.modulus); stat_in = STATUS_NO_INV;
                  end else begin
                     res_in = '0;
                  end
               end else begin
                  st_in = S_RED;
               end
            end
         end
         S_RED: begin
            dv_start = 1'b1;
            acc_in = (m_ff == MW'(1)) ? '0 : MW'(1);
            st_in = S_REDW;
         end
         S_REDW: if (dv_done) begin
            sq_in = dv_r[MW-1:0]; st_in = S_BIT;
         end
         S_BIT: begin
            if (e_ff == '0) begin
               st_in = S_FIN;
            end else if (e_ff[0]) begin
               mm_start = 1'b1; st_in = S_MULW;
            end else begin
               mm_start = 1'b1; mm_a = sq_ff; st_in = S_SQW;
            end
         end
         S_MULW: if (mm_done) begin
            acc_in = mm_r; mm_start = 1'b1; mm_a = sq_ff; st_in = S_SQW;
         end
         S_SQW: begin
            mm_a = sq_ff;
            if (mm_done) begin
               sq_in = mm_r; e_in = e_ff >> 1; st_in = S_BIT;
            end
         end
         S_FIN: begin
            st_in = S_OUT;
            if (!eneg_ff) begin
               res_in = pneg_ff ? DW'(-{1'b0, acc_ff}) : DW'(acc_ff);
            end else if (acc_ff == '0) begin
               res_in = DW'(m_ff); stat_in = STATUS_NO_INV;
            end else begin
               r0_in = acc_ff; r1_in = m_ff; c0_in = CW'(1); c1_in = '0; st_in = S_EUC;
            end
         end
         S_EUC: begin
            if (r1_ff == '0) begin
               st_in = S_OUT;
               if (r0_ff != MW'(1)) begin
                  res_in = DW'(m_ff); stat_in = STATUS_NO_INV;
               end else begin
                  xneg = c0_ff[CW-1];
                  xmag = xneg ? CW'(-c0_ff) : CW'(c0_ff);
                  rn = (xneg != pneg_ff) && (xmag != '0);
                  res_in = rn ? DW'(-xmag) : DW'(xmag);
               end
            end else begin
               dv_start = 1'b1; dv_num = DW'(r0_ff); dv_den = DW'(r1_ff); st_in = S_EUCW;
            end
         end
         S_EUCW: begin
            dv_num = DW'(r0_ff); dv_den = DW'(r1_ff);
            if (dv_done) st_in = S_EUCU;
         end
         S_EUCU: begin
            // quotient times c1 stays small: coefficients are bounded by m
            qc = CW'($signed({1'b0, dv_q}) * c1_ff);
            ct = c0_ff - qc;
            r0_in = r1_ff; r1_in = dv_r[MW-1:0];
            c0_in = c1_ff; c1_in = ct; st_in = S_EUC;
         end
         S_OUT: if (rsp.ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; sq_ff <= sq_in; acc_ff <= acc_in; e_ff <= e_in;
      eneg_ff <= eneg_in; pneg_ff <= pneg_in; r0_ff <= r0_in; r1_ff <= r1_in;
      c0_ff <= c0_in; c1_ff <= c1_in; res_ff <= res_in; stat_ff <= stat_in;
      bmag_ff <= bmag_in;
      if (reset) st_ff <= S_IDLE;
      else st_ff <= st_in;
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req.ready) else $error("accept while busy");
   a_zero_mod: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && stat_ff == STATUS_ZERO_MOD) |-> (res_ff == '0))
      else $error("zero modulus result");
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> (st_ff == S_MULW || st_ff == S_SQW)) else $error("stray multiply");
`endif
endmodule

@@ sim/mpi_checker.sv @@
module mpi_checker
   import mpi_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [DATA_WIDTH-1:0] req_base,
   input logic [DATA_WIDTH-1:0] req_exponent,
   input logic [DATA_WIDTH-2:0] req_modulus,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_result,
   input logic [1:0] rsp_status,
   output int fail_count,
   output int pending_count,
   output int beats_checked
);
   typedef struct packed {
      logic [DATA_WIDTH-1:0] result;
      logic [1:0] status;
   } power_type;

   power_type expected_powers[$];

   // (a*b) mod m on magnitudes below m
   function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] m);
      logic [63:0] r;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = r + r;
         if (r >= m) r = r - m;
         if (b[i]) begin
            r = r + a;
            if (r >= m) r = r - m;
         end
      end
      return r;
   endfunction

   function automatic power_type predict_power(logic [DATA_WIDTH-1:0] b,
                                               logic [DATA_WIDTH-1:0] e,
                                               logic [DATA_WIDTH-2:0] mod_in);
      power_type p;
      logic [63:0] m, bmag, emag, sq, acc, r0, r1, q, rt, rmag;
      logic [DATA_WIDTH-1:0] bneg_val, eneg_val;
      longint c0, c1, ct;
      logic bneg, eneg, pneg, rneg;
      m = 64'(mod_in);
      bneg = b[DATA_WIDTH-1];
      eneg = e[DATA_WIDTH-1];
      bneg_val = -b;
      eneg_val = -e;
      bmag = bneg ? 64'(bneg_val) : 64'(b);
      emag = eneg ? 64'(eneg_val) : 64'(e);
      if (eneg && e == {1'b1, {(DATA_WIDTH-1){1'b0}}}) emag = 64'(1) << (DATA_WIDTH-1);
      rneg = 0;
      rmag = '0;
      p.status = STATUS_OK;
      if (m == 0) begin
         p.status = STATUS_ZERO_MOD;
      end else if (b == 0 && e == 0) begin
         rmag = m; p.status = STATUS_ZERO_ZERO;
      end else if (e == 0) begin
         rmag = (m == 1) ? 64'(0) : 64'(1);
      end else if (b == 0) begin
         if (eneg) begin
            rmag = m; p.status = STATUS_NO_INV;
         end
      end else begin
         sq = bmag % m;
         acc = 64'(1) % m;
         pneg = bneg && emag[0];
         while (emag != 0) begin
            if (emag[0]) acc = mul_reduce(acc, sq, m);
            sq = mul_reduce(sq, sq, m);
            emag = emag >> 1;
         end
         if (!eneg) begin
            rmag = acc;
            rneg = pneg && acc != 0;
         end else if (acc == 0) begin
            rmag = m; p.status = STATUS_NO_INV;
         end else begin
            r0 = acc; r1 = m; c0 = 1; c1 = 0;
            while (r1 != 0) begin
               q = r0 / r1;
               rt = r0 - q * r1;
               ct = c0 - longint'(q) * c1;
               r0 = r1; r1 = rt; c0 = c1; c1 = ct;
            end
            if (r0 != 1) begin
               rmag = m; p.status = STATUS_NO_INV;
            end else begin
               rmag = (c0 < 0) ? 64'(-c0) : 64'(c0);
               rneg = ((c0 < 0) != pneg) && rmag != 0;
            end
         end
      end
      p.result = rneg ? DATA_WIDTH'(-rmag) : DATA_WIDTH'(rmag);
      return p;
   endfunction

   always @(posedge clock) begin
      power_type want;
      int fails;
      fails = 0;
      if (reset) begin
         fail_count <= 0;
         beats_checked <= 0;
         pending_count <= 0;
         expected_powers.delete();
      end else begin
         if (req_valid && req_ready)
            expected_powers.push_back(predict_power(req_base, req_exponent, req_modulus));
         if (rsp_valid && rsp_ready) begin
            beats_checked <= beats_checked + 1;
            if (expected_powers.size() == 0) begin
               $error("result beat with nothing expected: result %0h status %0d",
                      rsp_result, rsp_status);
               fails++;
            end else begin
               want = expected_powers.pop_front();
               if (want.result !== rsp_result) begin
                  $error("result: expected %0h actual %0h", want.result, rsp_result);
                  fails++;
               end
               if (want.status !== rsp_status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_status);
                  fails++;
               end
            end
         end
         fail_count <= fail_count + fails;
         pending_count <= expected_powers.size();
      end
   end
endmodule

@@ sim/tb_modular_power_with_inverse.sv @@
module tb_modular_power_with_inverse;
   localparam int DW = 32;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

   logic clock = 0;
   logic reset = 1;
   int fail_count, pending_count, beats_checked;
   int send_idle_pct = 0, stall_pct = 0;
   bit hold_off = 0;
   longint cycle_count = 0;

   mpi_req_if #(.DATA_WIDTH(DW)) req ();
   mpi_rsp_if #(.DATA_WIDTH(DW)) rsp ();

   modular_power_with_inverse #(.DATA_WIDTH(DW)) i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   mpi_checker #(.DATA_WIDTH(DW)) i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_base(req.base),
      .req_exponent(req.exponent), .req_modulus(req.modulus),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_result(rsp.result),
      .rsp_status(rsp.status),
      .fail_count(fail_count), .pending_count(pending_count),
      .beats_checked(beats_checked)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      req.valid = 0;
      req.base = 0;
      req.exponent = 0;
      req.modulus = 0;
      rsp.ready = 0;
   end

   // receiver: random stalls, or a long hold-off while the sender keeps offering
   always @(negedge clock) begin
      if (reset || hold_off) rsp.ready <= 0;
      else rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // valid stays up across back-to-back beats; drops only in idle gaps
   task automatic send_beat(logic [DW-1:0] b, logic [DW-1:0] e, logic [DW-1:0] m);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.base <= b;
      req.exponent <= e;
      req.modulus <= m[DW-2:0];
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_beats();
      req.valid <= 0;
      while (pending_count != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DW-1:0] pick_modulus();
      case ($urandom_range(5))
         0: return DW'(1);
         1: return DW'($urandom_range(2, 30));
         2: return MAXV;
         3: return DW'($urandom_range(2, 65535));
         default: return DW'($urandom) & MAXV;
      endcase
   endfunction

   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(6))
         0: return 0;
         1: return MINV;
         2: return DW'($urandom_range(1, 9));
         3: return -DW'($urandom_range(1, 9));
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (n) send_beat(pick_value(), pick_value(), pick_modulus());
      drain_beats();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // zero modulus, 0**0, 0**neg, x**0, mod 1, no inverse, extremes
      send_beat(5, 3, 0);
      send_beat(0, 0, 7);
      send_beat(0, -1, 7);
      send_beat(0, 5, 7);
      send_beat(9, 0, 7);
      send_beat(9, 0, 1);
      send_beat(3, -2, 1);
      send_beat(4, -1, 8);
      send_beat(7, -1, 7);
      send_beat(3, -1, 7);
      send_beat(-3, -3, 11);
      send_beat(-2, 3, 5);
      send_beat(-5, 2, 5);
      send_beat(MINV, MAXV, MAXV);
      send_beat(MAXV, MINV, MAXV);
      send_beat(MINV, MINV, 1000003);
      send_beat(MAXV, MAXV, 2);
      send_beat(-1, MINV, MAXV);
      send_beat(2, 30, MAXV);
      send_beat(12345, -7, 65537);
      drain_beats();
      random_phase(10, 0, 0);
      // long hold-off so the block backs up
      fork
         begin
            hold_off = 1;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_idle_pct = 0;
            repeat (3) send_beat($urandom, DW'($urandom_range(1, 40)), pick_modulus());
         end
      join
      drain_beats();
      random_phase(25, 87, 0);
      random_phase(25, 0, 87);
      random_phase(20, 30, 30);
      repeat (200) @(posedge clock);
      $display("covered special cases, extreme fields and %0d checked results", beats_checked);
      $display("with sender gaps, receiver stalls and one long back-pressure stretch");
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

@@ sim.f @@
sv/mpi_pkg.sv
sv/mpi_if.sv
sv/mpi_mulmod.sv
sv/mpi_divider.sv
sv/modular_power_with_inverse.sv
sim/mpi_checker.sv
sim/tb_modular_power_with_inverse.sv
